// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the OLED page refresh streamer.
// Synthesis builds see empty macro bodies; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, held off while reset is asserted (active low).
`define OPRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("oprs assertion failed");

// Checked on every rising edge, reset included.
`define OPRS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("oprs assertion failed");

`else

`define OPRS_ASSERT(lbl, clk, rst_n, prop)
`define OPRS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/oprs_pkg.sv =====
// Shared types and constants for the OLED page refresh streamer.
// No dependencies; imported by oprs_frame_store and the top level.
`default_nettype none

package oprs_pkg;

    // panel command bytes sent ahead of each page
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h02;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam int         HEADER_LEN    = 3;

    // input item kinds, carried on tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // single-bit write into one byte of the frame store
    typedef struct packed {
        logic       we;
        logic [2:0] bit_sel;
        logic       on;
    } t_pix_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/oprs_frame_store.sv =====
// Page-packed frame store: one byte per column per page, bit-granular writes,
// registered reads, and a clearing sweep after reset. Depends on oprs_pkg.
`default_nettype none

module oprs_frame_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  oprs_pkg::t_pix_cmd     i_wr,
    input  wire  [ADDR_W-1:0]      i_wr_addr,
    input  wire                    i_rd_en,
    input  wire  [ADDR_W-1:0]      i_rd_addr,
    output logic [7:0]             o_rd_data,
    output logic                   o_busy
);
    import oprs_pkg::*;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // clearing sweep, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.we) begin
            r_mem[i_wr_addr][i_wr.bit_sel] <= i_wr.on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

// ===== rtl/core/oled_page_refresh_streamer.sv =====
// A fetch transaction shows its byte on the master side in the cycle after acceptance.
// Throughput: one transaction per cycle while the master side keeps tready high and the frame
// store is not clearing; the single output register is the only buffer, so a stalled result holds off the next input.
// Reset (i_rst_n low, synchronous) zeroes page and byte counters, then the frame store is
// cleared one byte per cycle, all PAGE_COUNT * 2**clog2(PANEL_WIDTH) bytes (1024 by default).
`default_nettype none

`include "assert_macros.svh"

module oled_page_refresh_streamer #(
    parameter int PANEL_WIDTH = 128,
    parameter int PAGE_COUNT  = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,   // pixel_x[6:0], pixel_y[12:7], pixel_on[13], zero
    input  wire         i_s_axis_tuser,   // kind[0]: 0 pixel write, 1 fetch
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // out_byte[7:0]
    output logic        o_m_axis_tuser,   // is_data[0]
    output logic        o_m_axis_tlast    // frame_end
);
    import oprs_pkg::*;

    localparam int COL_W  = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int DEPTH  = PAGE_COUNT << COL_W;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(PANEL_WIDTH + HEADER_LEN);

    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(HEADER_LEN + PANEL_WIDTH - 1);
    localparam logic [POS_W-1:0]  POS_HDR   = POS_W'(HEADER_LEN);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

    // input fields
    logic       in_kind;
    logic [6:0] in_x;
    logic [5:0] in_y;
    logic       in_on;

    logic       accept;
    logic       fetch;
    logic       pix_ok;

    logic [POS_W-1:0]  r_pos;
    logic [PAGE_W-1:0] r_page;
    logic [POS_W-1:0]  n_pos;
    logic [PAGE_W-1:0] n_page;
    logic              n_last;

    logic              r_out_valid;
    logic              r_is_data;
    logic              r_last;
    logic [7:0]        r_cmd;
    logic [7:0]        n_cmd;

    t_pix_cmd          wr_cmd;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [COL_W-1:0]  rd_col;
    logic [7:0]        rd_data;
    logic              store_busy;

    assign in_kind = i_s_axis_tuser;
    assign in_x    = i_s_axis_tdata[6:0];
    assign in_y    = i_s_axis_tdata[12:7];
    assign in_on   = i_s_axis_tdata[13];

    assign o_s_axis_tready = !store_busy && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign fetch           = accept && (in_kind == KIND_FETCH);

    // off-panel writes are dropped
    assign pix_ok = (int'(in_x) < PANEL_WIDTH) && (int'(in_y[5:3]) < PAGE_COUNT);

    always_comb begin
        wr_cmd.we      = accept && (in_kind == KIND_PIXEL) && pix_ok;
        wr_cmd.bit_sel = in_y[2:0];
        wr_cmd.on      = in_on;
        wr_addr        = ADDR_W'({PAGE_W'(in_y[5:3]), COL_W'(in_x)});
    end

    assign rd_col  = COL_W'(r_pos - POS_HDR);
    assign rd_addr = ADDR_W'({r_page, rd_col});

    oprs_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_cmd),
        .i_wr_addr (wr_addr),
        .i_rd_en   (fetch),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_busy    (store_busy)
    );

    // stream position and command byte for the current fetch
    always_comb begin
        n_pos  = r_pos;
        n_page = r_page;
        n_last = 1'b0;
        if (r_pos == POS_LAST) begin
            n_pos = '0;
            if (r_page == PAGE_LAST) begin
                n_page = '0;
                n_last = 1'b1;
            end else begin
                n_page = r_page + 1'b1;
            end
        end else begin
            n_pos = r_pos + 1'b1;
        end

        priority if (r_pos == POS_W'(0)) begin
            n_cmd = CMD_PAGE_BASE + 8'(r_page);
        end else if (r_pos == POS_W'(1)) begin
            n_cmd = CMD_COL_LOW;
        end else begin
            n_cmd = CMD_COL_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_page      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fetch) begin
                r_pos       <= n_pos;
                r_page      <= n_page;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_is_data <= (r_pos >= POS_HDR);
            r_last    <= n_last;
            r_cmd     <= n_cmd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_is_data ? rd_data : r_cmd;
    assign o_m_axis_tuser  = r_is_data;
    assign o_m_axis_tlast  = r_last;

    `OPRS_ASSERT(a_no_accept_while_clearing, i_clk, i_rst_n, store_busy |-> !o_s_axis_tready)
    `OPRS_ASSERT(a_no_accept_into_stall, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
    `OPRS_ASSERT(a_frame_end_on_data, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
    `OPRS_ASSERT(a_counters_in_range, i_clk, i_rst_n,
        (int'(r_pos) < HEADER_LEN + PANEL_WIDTH) && (int'(r_page) < PAGE_COUNT))
    `OPRS_ASSERT(a_page_cmd_after_end, i_clk, i_rst_n,
        (fetch && n_last) |=> (r_pos == POS_W'(0) && r_page == PAGE_W'(0)))

endmodule

`default_nettype wire
